// File: rtl/core/stt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_pkg
// Shared types, codes and sizes for the software timer table core.
// ----------------------------------------------------------------------------
package stt_pkg;

    // table geometry
    localparam int NUM_SLOTS   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CMP_W       = (SLOT_W > 3) ? SLOT_W : 3;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int TIME_W      = 16;

    // command codes
    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DELETE  = 2'd1,
        CMD_TICK    = 2'd2,
        CMD_SERVICE = 2'd3
    } cmd_t;

    // result kinds
    typedef enum logic [2:0] {
        KIND_CREATED = 3'd0,
        KIND_FULL    = 3'd1,
        KIND_DELETED = 3'd2,
        KIND_FIRED   = 3'd3,
        KIND_NONE    = 3'd4
    } kind_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_RUN   = 2'd1,
        ST_FLUSH = 2'd2
    } state_t;

    // token walking along the row of slot cells
    typedef struct packed {
        logic              vld;
        logic              svc;
        logic [TIME_W-1:0] period;
        logic [CNT_W-1:0]  cnt;
    } tok_t;

    // per-cell status towards the controller
    typedef struct packed {
        logic hit;
        logic stop;
    } cell_evt_t;

    // row status collected for the controller
    typedef struct packed {
        logic             hit;
        logic             done;
        logic [CMP_W-1:0] idx;
    } chain_evt_t;

endpackage

// File: rtl/core/stt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_cell
// One timer slot: active mark, expiry and period, plus the token stage that
// hands the create or service token on to the next slot.
// ----------------------------------------------------------------------------
module stt_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      step_en,
    input  logic [stt_pkg::TIME_W-1:0] tick,
    input  logic                      del_en,
    input  logic [stt_pkg::CMP_W-1:0] del_slot,
    input  logic [stt_pkg::CMP_W-1:0] cell_idx,
    input  stt_pkg::tok_t             tok_in,
    output stt_pkg::tok_t             tok_out,
    output stt_pkg::cell_evt_t        evt
);

    logic                       active_reg, active_next;
    logic [stt_pkg::TIME_W-1:0] expiry_reg, expiry_next;
    logic [stt_pkg::TIME_W-1:0] period_reg, period_next;
    stt_pkg::tok_t              tok_reg, tok_next;

    logic due;
    logic hit;
    logic stop;

    // slot evaluation for the token held here
    always_comb begin
        due  = active_reg && (tick > expiry_reg);
        hit  = tok_reg.vld && (tok_reg.svc ? due : !active_reg);
        stop = hit && (!tok_reg.svc ||
                       (tok_reg.cnt == stt_pkg::CNT_W'(stt_pkg::MAX_RESULTS - 1)));
        evt.hit  = hit;
        evt.stop = stop;
    end

    // token handed to the neighbour
    always_comb begin
        tok_out = tok_reg;
        if (hit) begin
            tok_out.cnt = stt_pkg::CNT_W'(tok_reg.cnt + 1'b1);
        end
        if (stop) begin
            tok_out.vld = 1'b0;
        end
    end

    // slot state update
    always_comb begin
        active_next = active_reg;
        expiry_next = expiry_reg;
        period_next = period_reg;
        tok_next    = step_en ? tok_in : tok_reg;
        if (del_en && (del_slot == cell_idx)) begin
            active_next = 1'b0;
        end else if (step_en && hit) begin
            if (tok_reg.svc) begin
                if (period_reg == '0) begin
                    active_next = 1'b0;
                end else begin
                    expiry_next = stt_pkg::TIME_W'(expiry_reg + period_reg);
                end
            end else begin
                active_next = 1'b1;
                period_next = tok_reg.period;
                expiry_next = stt_pkg::TIME_W'(tick + tok_reg.period);
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            tok_reg    <= '0;
        end else begin
            active_reg <= active_next;
            tok_reg    <= tok_next;
        end
    end

    // slot payload
    always_ff @(posedge aclk) begin
        expiry_reg <= expiry_next;
        period_reg <= period_next;
    end

endmodule

// File: rtl/core/stt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_ctrl
// Command sequencer: accepts commands, keeps the tick counter, launches
// tokens into the slot row and orders the results onto the output register.
// ----------------------------------------------------------------------------
module stt_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_command,
    input  logic [15:0]                s_period,
    input  logic [2:0]                 s_slot,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [2:0]                 m_kind,
    output logic [2:0]                 m_slot_index,
    output logic                       m_last,
    input  stt_pkg::chain_evt_t        evt,
    output logic                       step_en,
    output logic [stt_pkg::TIME_W-1:0] tick,
    output logic                       del_en,
    output logic [stt_pkg::CMP_W-1:0]  del_slot,
    output stt_pkg::tok_t              inject
);

    stt_pkg::state_t            state_reg, state_next;
    logic                       svc_reg, svc_next;
    logic [stt_pkg::TIME_W-1:0] tick_reg, tick_next;
    logic                       pend_reg, pend_next;
    logic [2:0]                 pend_idx_reg, pend_idx_next;
    logic                       m_valid_reg, m_valid_next;
    stt_pkg::kind_t             kind_reg, kind_next;
    logic [2:0]                 idx_reg, idx_next;
    logic                       last_reg, last_next;

    logic           out_free;
    logic           accept;
    logic           emit;
    stt_pkg::kind_t emit_kind;
    logic [2:0]     emit_idx;
    logic           emit_last;

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == stt_pkg::ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign step_en  = out_free;
    assign tick     = tick_reg;
    assign del_slot = stt_pkg::CMP_W'(s_slot);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            stt_pkg::ST_IDLE: begin
                if (accept && ((s_command == stt_pkg::CMD_CREATE) ||
                               (s_command == stt_pkg::CMD_SERVICE))) begin
                    state_next = stt_pkg::ST_RUN;
                end
            end
            stt_pkg::ST_RUN: begin
                if (out_free && evt.done) begin
                    state_next = svc_reg ? stt_pkg::ST_FLUSH : stt_pkg::ST_IDLE;
                end
            end
            stt_pkg::ST_FLUSH: begin
                if (out_free) begin
                    state_next = stt_pkg::ST_IDLE;
                end
            end
            default: state_next = stt_pkg::ST_IDLE;
        endcase
    end

    // outputs, tick counter and pending fired slot
    always_comb begin
        emit          = 1'b0;
        emit_kind     = stt_pkg::KIND_NONE;
        emit_idx      = '0;
        emit_last     = 1'b1;
        svc_next      = svc_reg;
        tick_next     = tick_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        del_en        = 1'b0;
        inject        = '0;
        case (state_reg)
            stt_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_command)
                        stt_pkg::CMD_DELETE: begin
                            emit      = 1'b1;
                            emit_kind = stt_pkg::KIND_DELETED;
                            emit_idx  = s_slot;
                            del_en    = 1'b1;
                        end
                        stt_pkg::CMD_TICK: begin
                            tick_next = stt_pkg::TIME_W'(tick_reg + 1'b1);
                        end
                        default: begin
                            inject.vld    = 1'b1;
                            inject.svc    = (s_command == stt_pkg::CMD_SERVICE);
                            inject.period = s_period;
                            svc_next      = (s_command == stt_pkg::CMD_SERVICE);
                        end
                    endcase
                end
            end
            stt_pkg::ST_RUN: begin
                if (out_free) begin
                    if (!svc_reg) begin
                        // create: first free slot or table full
                        if (evt.hit) begin
                            emit      = 1'b1;
                            emit_kind = stt_pkg::KIND_CREATED;
                            emit_idx  = evt.idx[2:0];
                        end else if (evt.done) begin
                            emit      = 1'b1;
                            emit_kind = stt_pkg::KIND_FULL;
                        end
                    end else if (evt.hit) begin
                        // service: hold back one result to know the last one
                        if (pend_reg) begin
                            emit      = 1'b1;
                            emit_kind = stt_pkg::KIND_FIRED;
                            emit_idx  = pend_idx_reg;
                            emit_last = 1'b0;
                        end
                        pend_next     = 1'b1;
                        pend_idx_next = evt.idx[2:0];
                    end
                end
            end
            stt_pkg::ST_FLUSH: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_kind = pend_reg ? stt_pkg::KIND_FIRED : stt_pkg::KIND_NONE;
                    emit_idx  = pend_reg ? pend_idx_reg : 3'd0;
                    pend_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        kind_next    = kind_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            kind_next    = emit_kind;
            idx_next     = emit_idx;
            last_next    = emit_last;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= stt_pkg::ST_IDLE;
            tick_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            svc_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tick_reg    <= tick_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            svc_reg     <= svc_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        kind_reg     <= kind_next;
        idx_reg      <= idx_next;
        last_reg     <= last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = kind_reg;
    assign m_slot_index = idx_reg;
    assign m_last       = last_reg;

endmodule

// File: rtl/core/software_timer_table_core.sv
`timescale 1ns / 1ps
// Tick: no result. Delete: result registered in the cycle after accept.
// Create: the token walks one slot cell per cycle, result is the first free
// slot or table full. Service: fired slots are reported during the row walk.
// One item in flight at a time; output stalls freeze the walk.
// Synchronous active-low reset clears active marks, tick counter and tokens.
// ----------------------------------------------------------------------------
// software_timer_table_core
// Timer slot table built as a row of slot cells with a command sequencer.
// ----------------------------------------------------------------------------
module software_timer_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [15:0] s_period,
    input  logic [2:0]  s_slot,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [2:0]  m_slot_index,
    output logic        m_last
);

    stt_pkg::tok_t              tok_link [stt_pkg::NUM_SLOTS+1];
    stt_pkg::cell_evt_t         cell_evt [stt_pkg::NUM_SLOTS];
    stt_pkg::chain_evt_t        evt;
    logic                       step_en;
    logic [stt_pkg::TIME_W-1:0] tick;
    logic                       del_en;
    logic [stt_pkg::CMP_W-1:0]  del_slot;

    // sequencer
    stt_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_period     (s_period),
        .s_slot       (s_slot),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_slot_index (m_slot_index),
        .m_last       (m_last),
        .evt          (evt),
        .step_en      (step_en),
        .tick         (tick),
        .del_en       (del_en),
        .del_slot     (del_slot),
        .inject       (tok_link[0])
    );

    // row of slot cells
    for (genvar i = 0; i < stt_pkg::NUM_SLOTS; i++) begin : g_cell
        stt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step_en  (step_en),
            .tick     (tick),
            .del_en   (del_en),
            .del_slot (del_slot),
            .cell_idx (stt_pkg::CMP_W'(i)),
            .tok_in   (tok_link[i]),
            .tok_out  (tok_link[i+1]),
            .evt      (cell_evt[i])
        );
    end

    // collect the status of the cell holding the token; a token leaving the row ends it
    always_comb begin
        evt      = '0;
        evt.done = tok_link[stt_pkg::NUM_SLOTS].vld;
        for (int i = 0; i < stt_pkg::NUM_SLOTS; i++) begin
            evt.hit  = evt.hit | cell_evt[i].hit;
            evt.done = evt.done | cell_evt[i].stop;
            evt.idx  = evt.idx | (cell_evt[i].hit ? stt_pkg::CMP_W'(i) : '0);
        end
    end

endmodule

// File: rtl/core/stt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stt_checker
// Port-level checks for the software timer table core, bound to the top.
// ----------------------------------------------------------------------------
module stt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_kind,
    input logic [2:0]  m_slot_index,
    input logic        m_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) &&
                                $stable(m_slot_index) && $stable(m_last))
        else $error("result changed while stalled");

    // only fired results may be followed by more from the same transaction
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> (m_kind == stt_pkg::KIND_FIRED))
        else $error("non-final result that is not a fired slot");

    // table full and nothing fired carry slot zero
    a_zero_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_kind == stt_pkg::KIND_FULL) || (m_kind == stt_pkg::KIND_NONE))
        |-> (m_slot_index == 3'd0))
        else $error("slot index not zero");

    // no new command while a service scan still owes results
    a_busy_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("input ready during service scan");

endmodule

bind software_timer_table_core stt_checker u_stt_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_kind       (m_kind),
    .m_slot_index (m_slot_index),
    .m_last       (m_last)
);
